/* rtl/sit_pkg.sv */
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the sorted integer table
// Table size, field widths, operation and status codes, cell controls and
// the sequencer states.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int INDEX_W = 7;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 7;
  localparam int WIDE_W  = (INDEX_W > COUNT_W) ? INDEX_W : COUNT_W;

  typedef enum logic [2:0] {
    K_INSERT_AT     = 3'd0,
    K_REMOVE_AT     = 3'd1,
    K_PUSH_BACK     = 3'd2,
    K_PUSH_FRONT    = 3'd3,
    K_POP_BACK      = 3'd4,
    K_POP_FRONT     = 3'd5,
    K_INSERT_SORTED = 3'd6,
    K_FIND          = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_UP   = 2'd2,
    CELL_DOWN = 2'd3
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_SEARCH = 3'd1,
    S_WALK   = 3'd2,
    S_EXEC   = 3'd3,
    S_RESP   = 3'd4
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [DATA_W-1:0]   read_value;
    logic [POS_W-1:0]    position;
    logic                found;
    logic [CNT_W-1:0]    count;
  } resp_t;

endpackage

/* rtl/sit_cell.sv */
// ----------------------------------------------------------------------------
// sit_cell: one storage cell of the table
// Holds one entry, takes a new value or a neighbor's entry on command, and
// compares the search key against its entry.
// ----------------------------------------------------------------------------
module sit_cell
  import sit_pkg::*;
(
  input  logic                     clk,
  input  cell_op_t                 op,
  input  logic signed [DATA_W-1:0] prev_entry,
  input  logic signed [DATA_W-1:0] next_entry,
  input  logic signed [DATA_W-1:0] ins_value,
  input  logic signed [DATA_W-1:0] key,
  output logic signed [DATA_W-1:0] entry,
  output logic                     key_lt,
  output logic                     key_eq
);

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  always_comb begin
    case (op)
      CELL_LOAD: entry_nxt = ins_value;
      CELL_UP:   entry_nxt = prev_entry;
      CELL_DOWN: entry_nxt = next_entry;
      default:   entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry  = entry_r;
  assign key_lt = key < entry_r;
  assign key_eq = key == entry_r;

endmodule

/* rtl/sorted_int_table_core.sv */
// ----------------------------------------------------------------------------
// sorted_int_table_core: fixed-capacity table of signed 32-bit entries
// A row of cells holds the entries; a sequencer runs insert, remove, push,
// pop, sorted insert and binary-search find on them.
// ----------------------------------------------------------------------------
// Each item carries one operation. Insert, remove, push and pop shift every
// later cell by one place at once, and the result is loaded into the output
// register in the execute state, or into a pending register while the output
// is still full. Find and sorted insert first run the binary search one probe
// per cycle, selecting the parallel compare flags of the probed cell, then step
// past each further equal entry while moving to the last equal position.
// A result that is not yet taken holds the sequencer before its next item.
// Entries beyond the current count have no defined contents.
// ----------------------------------------------------------------------------
module sorted_int_table_core
  import sit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // index[6:0], value[38:7], zero pad
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // read_value[31:0], position[38:32],
                                  // found[39], count[46:40], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  state_t                   state_r, state_nxt;
  kind_t                    kind_r, kind_nxt;
  logic [INDEX_W-1:0]       index_r, index_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [COUNT_W-1:0]       count_r, count_nxt;
  logic [COUNT_W-1:0]       lo_r, lo_nxt;
  logic [COUNT_W-1:0]       hip1_r, hip1_nxt;
  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic                     hit_r, hit_nxt;
  resp_t                    pend_r, pend_nxt;
  resp_t                    out_r, out_nxt;
  logic                     out_valid_r, out_valid_nxt;

  logic signed [DATA_W-1:0] entry_v [DEPTH];
  logic [DEPTH-1:0]         lt_v;
  logic [DEPTH-1:0]         eq_v;
  cell_op_t                 cell_op [DEPTH];

  logic [COUNT_W:0]         mid_sum;
  logic [COUNT_W-1:0]       mid;
  logic [IDX_W-1:0]         mid_idx;
  logic [POS_W-1:0]         walk_pos;
  logic [IDX_W-1:0]         walk_idx;

  logic                     full;
  logic                     ins_en;
  logic                     rem_en;
  logic [COUNT_W-1:0]       edit_pos;
  logic [WIDE_W-1:0]        idx_w;
  logic [WIDE_W-1:0]        cnt_w;
  logic [COUNT_W-1:0]       count_new;
  resp_t                    resp;
  logic                     out_free;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] prev_e;
    logic signed [DATA_W-1:0] next_e;
    if (i == 0) begin : g_first
      assign prev_e = entry_v[i];
    end else begin : g_prev
      assign prev_e = entry_v[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_e = entry_v[i];
    end else begin : g_next
      assign next_e = entry_v[i+1];
    end
    sit_cell u_cell (
      .clk        (clk),
      .op         (cell_op[i]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .ins_value  (value_r),
      .key        (value_r),
      .entry      (entry_v[i]),
      .key_lt     (lt_v[i]),
      .key_eq     (eq_v[i])
    );
  end

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hip1_r} - {{COUNT_W{1'b0}}, 1'b1};
  assign mid      = mid_sum[COUNT_W:1];
  assign mid_idx  = mid[IDX_W-1:0];
  assign walk_pos = pos_r + POS_W'(1);
  assign walk_idx = walk_pos[IDX_W-1:0];

  assign full  = count_r == COUNT_W'(DEPTH);
  assign idx_w = WIDE_W'(index_r);
  assign cnt_w = WIDE_W'(count_r);

  always_comb begin
    ins_en          = 1'b0;
    rem_en          = 1'b0;
    edit_pos        = '0;
    resp.status     = STAT_OK;
    resp.read_value = '0;
    resp.position   = '0;
    resp.found      = 1'b0;
    unique case (kind_r)
      K_INSERT_AT: begin
        edit_pos = COUNT_W'(index_r);
        if (idx_w > cnt_w) begin
          resp.status = STAT_BAD;
        end else if (full) begin
          resp.status = STAT_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      K_REMOVE_AT: begin
        edit_pos = COUNT_W'(index_r);
        if (idx_w >= cnt_w) begin
          resp.status = STAT_BAD;
        end else begin
          rem_en = 1'b1;
        end
      end
      K_PUSH_BACK, K_PUSH_FRONT: begin
        edit_pos = (kind_r == K_PUSH_BACK) ? count_r : '0;
        if (full) begin
          resp.status = STAT_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      K_POP_BACK, K_POP_FRONT: begin
        edit_pos = (kind_r == K_POP_BACK) ? count_r - COUNT_W'(1) : '0;
        if (count_r == '0) begin
          resp.status = STAT_BAD;
        end else begin
          rem_en = 1'b1;
        end
      end
      K_INSERT_SORTED: begin
        edit_pos      = COUNT_W'(pos_r);
        resp.position = pos_r;
        if (full) begin
          resp.status = STAT_FULL;
        end else begin
          ins_en = 1'b1;
        end
      end
      default: begin
        resp.position = pos_r;
        resp.found    = hit_r;
      end
    endcase
    if (rem_en) begin
      resp.read_value = entry_v[edit_pos[IDX_W-1:0]];
    end
    if (ins_en) begin
      count_new = count_r + COUNT_W'(1);
    end else if (rem_en) begin
      count_new = count_r - COUNT_W'(1);
    end else begin
      count_new = count_r;
    end
    resp.count = CNT_W'(count_new);
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
      if (state_r == S_EXEC && ins_en) begin
        if (COUNT_W'(i) == edit_pos) begin
          cell_op[i] = CELL_LOAD;
        end else if (COUNT_W'(i) > edit_pos) begin
          cell_op[i] = CELL_UP;
        end
      end else if (state_r == S_EXEC && rem_en) begin
        if (COUNT_W'(i) >= edit_pos) begin
          cell_op[i] = CELL_DOWN;
        end
      end
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    index_nxt     = index_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hip1_nxt      = hip1_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = state_r == S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = kind_t'(in_tuser);
          index_nxt = in_tdata[6:0];
          value_nxt = in_tdata[38:7];
          lo_nxt    = '0;
          hip1_nxt  = count_r;
          pos_nxt   = '0;
          hit_nxt   = 1'b0;
          if (kind_t'(in_tuser) == K_INSERT_SORTED || kind_t'(in_tuser) == K_FIND) begin
            state_nxt = S_SEARCH;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_SEARCH: begin
        if (lo_r >= hip1_r) begin
          pos_nxt   = POS_W'(lo_r);
          state_nxt = S_EXEC;
        end else if (eq_v[mid_idx]) begin
          pos_nxt   = POS_W'(mid);
          state_nxt = S_WALK;
        end else if (lt_v[mid_idx]) begin
          hip1_nxt = mid;
        end else begin
          lo_nxt = mid + COUNT_W'(1);
        end
      end
      S_WALK: begin
        if (COUNT_W'(walk_pos) < hip1_r && eq_v[walk_idx]) begin
          pos_nxt = walk_pos;
        end else begin
          hit_nxt   = 1'b1;
          state_nxt = S_EXEC;
          if (kind_r == K_INSERT_SORTED) begin
            pos_nxt = walk_pos;
          end
        end
      end
      S_EXEC: begin
        count_nxt = count_new;
        if (out_free) begin
          out_nxt       = resp;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          pend_nxt  = resp;
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    index_r <= index_nxt;
    value_r <= value_nxt;
    lo_r    <= lo_nxt;
    hip1_r  <= hip1_nxt;
    pos_r   <= pos_nxt;
    hit_r   <= hit_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.count, out_r.found, out_r.position, out_r.read_value};
  assign out_tuser  = out_r.status;

endmodule

/* bench/tb_sorted_int_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_int_table_core: self-checking bench for the sorted integer table
// Named tests drive insert, remove, push, pop, sorted insert and find items
// through the input stream. A local table model predicts every result, and
// a checker compares each result with the oldest prediction. The sender runs
// in random bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_sorted_int_table_core;
  import sit_pkg::*;

  localparam int CLK_HALF   = 4;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 80;
  localparam int HOLD_LEN   = 200;
  localparam int MAX_PRINTS = 20;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;

  logic signed [DATA_W-1:0] tbl [DEPTH];
  int    tbl_cnt = 0;
  resp_t pending_resp [$];

  int  err_count   = 0;
  int  n_sent      = 0;
  int  n_checked   = 0;
  int  n_full      = 0;
  int  n_bad       = 0;
  int  n_found     = 0;
  int  kind_hits [8];
  int  burst_left  = 0;
  bit  steady_send = 1'b0;
  bit  hold_req    = 1'b0;
  int  hold_left   = 0;
  int  rcv_mode    = 0;
  int  rcv_left    = 0;

  sorted_int_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic logic [POS_W-1:0] tbl_search(logic signed [DATA_W-1:0] v,
                                                  output bit hit);
    int lo;
    int hi;
    int mid;
    hit = 1'b0;
    lo  = 0;
    hi  = tbl_cnt - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (v == tbl[mid]) begin
        while (mid < hi && tbl[mid+1] == v) mid++;
        hit = 1'b1;
        return POS_W'(mid);
      end else if (v < tbl[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return POS_W'(lo);
  endfunction

  function automatic void tbl_place(int p, logic signed [DATA_W-1:0] v);
    for (int i = tbl_cnt; i > p; i--) tbl[i] = tbl[i-1];
    tbl[p] = v;
    tbl_cnt++;
  endfunction

  function automatic logic signed [DATA_W-1:0] tbl_take(int p);
    logic signed [DATA_W-1:0] v;
    v = tbl[p];
    for (int i = p; i < tbl_cnt - 1; i++) tbl[i] = tbl[i+1];
    tbl_cnt--;
    return v;
  endfunction

  function automatic resp_t table_apply(kind_t k, logic [INDEX_W-1:0] idx,
                                        logic signed [DATA_W-1:0] v);
    resp_t r;
    bit hit;
    bit full;
    logic [POS_W-1:0] p;
    r = '0;
    r.status = STAT_OK;
    full = (tbl_cnt >= DEPTH);
    case (k)
      K_INSERT_AT: begin
        if (idx > tbl_cnt) r.status = STAT_BAD;
        else if (full) r.status = STAT_FULL;
        else tbl_place(idx, v);
      end
      K_REMOVE_AT: begin
        if (idx >= tbl_cnt) r.status = STAT_BAD;
        else r.read_value = tbl_take(idx);
      end
      K_PUSH_BACK: begin
        if (full) r.status = STAT_FULL;
        else tbl_place(tbl_cnt, v);
      end
      K_PUSH_FRONT: begin
        if (full) r.status = STAT_FULL;
        else tbl_place(0, v);
      end
      K_POP_BACK: begin
        if (tbl_cnt == 0) r.status = STAT_BAD;
        else r.read_value = tbl_take(tbl_cnt - 1);
      end
      K_POP_FRONT: begin
        if (tbl_cnt == 0) r.status = STAT_BAD;
        else r.read_value = tbl_take(0);
      end
      K_INSERT_SORTED: begin
        p = tbl_search(v, hit);
        if (hit) p++;
        r.position = p;
        if (full) r.status = STAT_FULL;
        else tbl_place(p, v);
      end
      default: begin
        r.position = tbl_search(v, hit);
        r.found    = hit;
      end
    endcase
    r.count = CNT_W'(tbl_cnt);
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(bit narrow);
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 5))
        0: return 32'sh8000_0000;
        1: return 32'sh7FFF_FFFF;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        4: return 32'sh8000_0001;
        default: return 32'sh7FFF_FFFE;
      endcase
    end
    if (narrow) return int'($urandom_range(0, 24)) - 12;
    return $urandom;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic send_item(kind_t k, logic [INDEX_W-1:0] idx,
                           logic signed [DATA_W-1:0] v);
    int gap;
    resp_t want;
    gap = 0;
    if (!steady_send && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, v, idx};
    in_tuser  <= k;
    if (burst_left > 0) burst_left--;
    do @(posedge clk); while (!in_tready);
    want = table_apply(k, idx, v);
    pending_resp.push_back(want);
    n_sent++;
    kind_hits[k]++;
    if (want.status == STAT_FULL) n_full++;
    if (want.status == STAT_BAD) n_bad++;
    if (want.found) n_found++;
  endtask

  // Receiver: a long hold on request, otherwise stretches of random readiness.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rcv_left == 0) begin
        rcv_mode = $urandom_range(0, 2);
        rcv_left = $urandom_range(10, 60);
      end
      rcv_left--;
      case (rcv_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_checked++;
      if (pending_resp.size() == 0) begin
        report_mismatch($sformatf("result with no item outstanding, data %h", out_tdata));
      end else begin
        want = pending_resp.pop_front();
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status exp %0d got %0d", want.status, out_tuser));
        if (out_tdata[31:0] !== want.read_value)
          report_mismatch($sformatf("read_value exp %h got %h",
                                    want.read_value, out_tdata[31:0]));
        if (out_tdata[38:32] !== want.position)
          report_mismatch($sformatf("position exp %0d got %0d",
                                    want.position, out_tdata[38:32]));
        if (out_tdata[39] !== want.found)
          report_mismatch($sformatf("found exp %0d got %0d", want.found, out_tdata[39]));
        if (out_tdata[46:40] !== want.count)
          report_mismatch($sformatf("count exp %0d got %0d", want.count, out_tdata[46:40]));
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (!in_tvalid && pending_resp.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[sorted_int_table_core] ERROR");
    $finish;
  end

  task automatic test_empty_table();
    send_item(K_POP_BACK, 0, 32'sd5);
    send_item(K_POP_FRONT, 0, 32'sd5);
    send_item(K_REMOVE_AT, 0, 32'sd5);
    send_item(K_FIND, 0, 32'sd9);
    send_item(K_INSERT_AT, 1, 32'sd3);
    send_item(K_INSERT_SORTED, 7'd64, 32'sd5);
    send_item(K_POP_BACK, 0, 32'sd0);
  endtask

  task automatic test_each_operation();
    send_item(K_PUSH_BACK, 0, 32'sh7FFF_FFFF);
    send_item(K_PUSH_FRONT, 0, 32'sh8000_0000);
    send_item(K_INSERT_AT, 1, 32'sd0);
    send_item(K_INSERT_AT, 3, -32'sd1);
    send_item(K_INSERT_AT, 5, 32'sd1);
    send_item(K_INSERT_SORTED, 0, 32'sd0);
    send_item(K_INSERT_SORTED, 0, 32'sd0);
    send_item(K_FIND, 0, 32'sd0);
    send_item(K_FIND, 0, 32'sh8000_0000);
    send_item(K_FIND, 0, 32'sh7FFF_FFFF);
    send_item(K_FIND, 0, 32'sd17);
    send_item(K_REMOVE_AT, 2, 32'sd0);
    send_item(K_REMOVE_AT, 7'd64, 32'sd0);
    send_item(K_REMOVE_AT, 7'(tbl_cnt), 32'sd0);
    send_item(K_POP_BACK, 0, 32'sd0);
    send_item(K_POP_FRONT, 0, 32'sd0);
    while (tbl_cnt > 0) send_item(K_REMOVE_AT, 0, 32'sd0);
  endtask

  task automatic test_full_table();
    while (tbl_cnt < DEPTH)
      send_item(K_INSERT_SORTED, INDEX_W'($urandom_range(0, DEPTH)), pick_value(1'b1));
    send_item(K_PUSH_BACK, 0, 32'sd1);
    send_item(K_PUSH_FRONT, 0, 32'sd1);
    send_item(K_INSERT_AT, 7'd64, 32'sd1);
    send_item(K_INSERT_AT, 0, 32'sd1);
    send_item(K_INSERT_SORTED, 0, 32'sd0);
    send_item(K_FIND, 0, tbl[10]);
    send_item(K_FIND, 0, 32'sh8000_0000);
    send_item(K_REMOVE_AT, 7'd64, 32'sd0);
    send_item(K_REMOVE_AT, 7'd63, 32'sd0);
    send_item(K_INSERT_AT, 7'd63, 32'sh7FFF_FFFF);
    while (tbl_cnt > 0)
      send_item($urandom_range(0, 1) ? K_POP_FRONT : K_REMOVE_AT,
                INDEX_W'($urandom_range(0, tbl_cnt - 1)), 32'sd0);
  endtask

  task automatic test_equal_runs();
    while (tbl_cnt < DEPTH) send_item(K_PUSH_BACK, 0, 32'sd7);
    send_item(K_FIND, 0, 32'sd7);
    send_item(K_INSERT_SORTED, 0, 32'sd7);
    send_item(K_FIND, 0, 32'sd6);
    send_item(K_FIND, 0, 32'sd8);
    while (tbl_cnt > 0) send_item(K_POP_BACK, 0, 32'sd0);
  endtask

  task automatic test_backpressure();
    steady_send = 1'b1;
    send_item(K_PUSH_BACK, 0, 32'sd1);
    hold_req = 1'b1;
    repeat (30) begin
      case ($urandom_range(0, 2))
        0: send_item(K_PUSH_BACK, 0, pick_value(1'b0));
        1: send_item(K_FIND, 0, pick_value(1'b0));
        default: send_item(K_POP_FRONT, 0, 32'sd0);
      endcase
    end
    steady_send = 1'b0;
  endtask

  task automatic test_random_mix(int n_items);
    int phase_left;
    int target;
    int r;
    bit sorted_phase;
    kind_t k;
    logic [INDEX_W-1:0] idx;
    logic signed [DATA_W-1:0] v;
    phase_left   = 0;
    target       = 0;
    sorted_phase = 1'b0;
    for (int i = 0; i < n_items; i++) begin
      if (phase_left == 0) begin
        sorted_phase = ($urandom_range(0, 1) == 1);
        target       = $urandom_range(0, DEPTH);
        phase_left   = $urandom_range(20, 80);
        steady_send  = ($urandom_range(0, 3) == 0);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        k   = kind_t'($urandom_range(0, 7));
        idx = INDEX_W'($urandom_range(0, DEPTH));
        v   = $urandom;
      end else begin
        if (r < 25) begin
          k = K_FIND;
        end else if (tbl_cnt < target || (tbl_cnt == target && $urandom_range(0, 1))) begin
          if (sorted_phase) begin
            k = K_INSERT_SORTED;
          end else begin
            case ($urandom_range(0, 3))
              0: k = K_INSERT_AT;
              1: k = K_PUSH_BACK;
              2: k = K_PUSH_FRONT;
              default: k = K_INSERT_SORTED;
            endcase
          end
        end else begin
          case ($urandom_range(0, 2))
            0: k = K_REMOVE_AT;
            1: k = K_POP_BACK;
            default: k = K_POP_FRONT;
          endcase
        end
        if (k == K_INSERT_AT)
          idx = ($urandom_range(0, 9) == 0 && tbl_cnt < DEPTH) ?
                INDEX_W'($urandom_range(tbl_cnt + 1, DEPTH)) :
                INDEX_W'($urandom_range(0, tbl_cnt));
        else if (k == K_REMOVE_AT)
          idx = ($urandom_range(0, 9) == 0 || tbl_cnt == 0) ?
                INDEX_W'($urandom_range(tbl_cnt, DEPTH)) :
                INDEX_W'($urandom_range(0, tbl_cnt - 1));
        else
          idx = INDEX_W'($urandom_range(0, DEPTH));
        if (k == K_FIND && tbl_cnt > 0 && $urandom_range(0, 1))
          v = tbl[$urandom_range(0, tbl_cnt - 1)];
        else
          v = pick_value(sorted_phase && $urandom_range(0, 4) != 0);
      end
      send_item(k, idx, v);
    end
    steady_send = 1'b0;
  endtask

  initial begin
    foreach (kind_hits[i]) kind_hits[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_table();
    test_each_operation();
    test_full_table();
    test_equal_runs();
    test_backpressure();
    test_random_mix(850);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Run: %0d items, %0d results checked; full %0d, bad index or empty %0d, hits %0d",
             n_sent, n_checked, n_full, n_bad, n_found);
    $display("Per kind: ins_at %0d rm_at %0d push_b %0d push_f %0d pop_b %0d pop_f %0d",
             kind_hits[K_INSERT_AT], kind_hits[K_REMOVE_AT], kind_hits[K_PUSH_BACK],
             kind_hits[K_PUSH_FRONT], kind_hits[K_POP_BACK], kind_hits[K_POP_FRONT]);
    $display("Per kind: sorted insert %0d, find %0d, mismatches %0d",
             kind_hits[K_INSERT_SORTED], kind_hits[K_FIND], err_count);
    if (err_count == 0) begin
      $display("[sorted_int_table_core] OK");
    end else begin
      $display("[sorted_int_table_core] ERROR");
    end
    $finish;
  end

endmodule
